/* rtl/core/dwsp_pkg.sv */
`timescale 1ns / 1ps

package dwsp_pkg;

	localparam int IDX_W  = 3;
	localparam int GAIN_W = 24;
	localparam int ILIM_W = 16;
	localparam int DLIM_W = 15;
	localparam int SPD_W  = 16;
	localparam int DRV_W  = 16;
	localparam int CFG_W  = 24;

	localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 24'd786432;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 24'd6554;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 24'd163840;
	localparam logic [ILIM_W-1:0] INTEG_LIMIT_RST = 16'd10000;
	localparam logic [DLIM_W-1:0] DRIVE_LIMIT_RST = 15'd7200;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [ILIM_W-1:0] integ_limit;
		logic [DLIM_W-1:0] drive_limit;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic adv;
		logic clr;
	} lane_ctl_t;

endpackage

/* rtl/core/dwsp_lane.sv */
`timescale 1ns / 1ps

module dwsp_lane #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dwsp_pkg::lane_ctl_t                ctl,
	input  dwsp_pkg::cfg_t                     cfg,
	input  logic signed [dwsp_pkg::SPD_W-1:0]  tgt,
	input  logic signed [dwsp_pkg::SPD_W-1:0]  meas,
	output logic signed [dwsp_pkg::DRV_W-1:0]  drive
);

	localparam int E_W   = dwsp_pkg::SPD_W + 1;
	localparam int D_W   = E_W + 1;
	localparam int P_W   = dwsp_pkg::GAIN_W + 1 + E_W;
	localparam int PD_W  = dwsp_pkg::GAIN_W + 1 + D_W;
	localparam int SUM_W = PD_W + 2;

	logic signed [E_W-1:0]   integ_q;
	logic signed [E_W-1:0]   perr_q;

	logic signed [E_W-1:0]   err;
	logic signed [E_W-1:0]   ibase;
	logic signed [D_W-1:0]   isum;
	logic signed [D_W-1:0]   lim;
	logic signed [D_W-1:0]   iclamp;
	logic signed [E_W-1:0]   inew;
	logic signed [D_W-1:0]   dlt;

	logic signed [E_W-1:0]   e_s1;
	logic signed [E_W-1:0]   i_s1;
	logic signed [D_W-1:0]   d_s1;

	logic signed [dwsp_pkg::GAIN_W:0] gp;
	logic signed [dwsp_pkg::GAIN_W:0] gi;
	logic signed [dwsp_pkg::GAIN_W:0] gd;

	logic signed [P_W-1:0]   pp_s2;
	logic signed [P_W-1:0]   pi_s2;
	logic signed [PD_W-1:0]  pd_s2;

	logic signed [SUM_W-1:0] sum_s3;

	logic                    neg;
	logic [SUM_W-1:0]        mag;
	logic [SUM_W-1:0]        shf;
	logic [SUM_W-1:0]        dl_ext;
	logic [dwsp_pkg::DLIM_W-1:0] sat;

	always_comb begin
		err    = E_W'({tgt[dwsp_pkg::SPD_W-1], tgt}) - E_W'({meas[dwsp_pkg::SPD_W-1], meas});
		ibase  = ctl.clr ? '0 : integ_q;
		isum   = {ibase[E_W-1], ibase} + {err[E_W-1], err};
		lim    = $signed({2'b00, cfg.integ_limit});
		if (isum > lim) begin
			iclamp = lim;
		end else if (isum < -lim) begin
			iclamp = -lim;
		end else begin
			iclamp = isum;
		end
		inew   = iclamp[E_W-1:0];
		dlt    = {err[E_W-1], err} - {perr_q[E_W-1], perr_q};
		gp     = $signed({1'b0, cfg.prop_gain});
		gi     = $signed({1'b0, cfg.integ_gain});
		gd     = $signed({1'b0, cfg.deriv_gain});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			perr_q  <= '0;
		end else if (ctl.take) begin
			integ_q <= inew;
			perr_q  <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			e_s1   <= err;
			i_s1   <= inew;
			d_s1   <= dlt;
			pp_s2  <= gp * e_s1;
			pi_s2  <= gi * i_s1;
			pd_s2  <= gd * d_s1;
			sum_s3 <= {{(SUM_W-P_W){pp_s2[P_W-1]}}, pp_s2}
				+ {{(SUM_W-P_W){pi_s2[P_W-1]}}, pi_s2}
				+ {{(SUM_W-PD_W){pd_s2[PD_W-1]}}, pd_s2};
		end
	end

	// truncate toward zero and saturate to drive_limit: shift the magnitude, clamp it, then restore sign
	always_comb begin
		neg    = sum_s3[SUM_W-1];
		mag    = neg ? SUM_W'(-sum_s3) : SUM_W'(sum_s3);
		shf    = mag >> GAIN_FRAC_BITS;
		dl_ext = {{(SUM_W-dwsp_pkg::DLIM_W){1'b0}}, cfg.drive_limit};
		sat    = (shf > dl_ext) ? cfg.drive_limit : shf[dwsp_pkg::DLIM_W-1:0];
		drive  = neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
	end

endmodule

/* rtl/core/dwsp_merge.sv */
`timescale 1ns / 1ps

module dwsp_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              vld_in,
	input  logic signed [dwsp_pkg::DRV_W-1:0] drive_l,
	input  logic signed [dwsp_pkg::DRV_W-1:0] drive_r,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [2*dwsp_pkg::DRV_W-1:0]      m_tdata,
	output logic                              adv
);

	logic                         vld_q;
	logic [2*dwsp_pkg::DRV_W-1:0] data_q;

	assign adv      = !vld_q || m_tready;
	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= {drive_r, drive_l};
		end
	end

endmodule

/* rtl/core/dual_wheel_speed_pid_unit.sv */
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tdata: targets and measured speeds, tuser: clear
// m_*      out  m_tvalid/m_tready    tdata: left and right drive
// cfg_*    in   cfg_wen              cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; an input beat passes
// the error/integral stage, multiplier stage, sum stage and output register in turn.
// Integral and previous-error state update at the input beat, so beats may
// follow each other in consecutive cycles. Reset clears the state and loads
// the default gains and limits. An output stall freezes the whole pipeline.

module dual_wheel_speed_pid_unit #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// target_left_speed, target_right_speed, measured_left_speed, measured_right_speed
	input  logic [4*dwsp_pkg::SPD_W-1:0]  s_tdata,
	// clear_integrals
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// drive_left, drive_right
	output logic [2*dwsp_pkg::DRV_W-1:0]  m_tdata,
	input  logic                          cfg_wen,
	input  logic [dwsp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dwsp_pkg::CFG_W-1:0]    cfg_data
);

	localparam int W = dwsp_pkg::SPD_W;

	dwsp_pkg::cfg_t      cfg_q;
	dwsp_pkg::lane_ctl_t ctl;
	logic                adv;
	logic                vld_s1;
	logic                vld_s2;
	logic                vld_s3;
	logic signed [dwsp_pkg::DRV_W-1:0] drive_l;
	logic signed [dwsp_pkg::DRV_W-1:0] drive_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= dwsp_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain  <= dwsp_pkg::INTEG_GAIN_RST;
			cfg_q.deriv_gain  <= dwsp_pkg::DERIV_GAIN_RST;
			cfg_q.integ_limit <= dwsp_pkg::INTEG_LIMIT_RST;
			cfg_q.drive_limit <= dwsp_pkg::DRIVE_LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				dwsp_pkg::REG_PROP_GAIN: begin
					cfg_q.prop_gain <= cfg_data[dwsp_pkg::GAIN_W-1:0];
				end
				dwsp_pkg::REG_INTEG_GAIN: begin
					cfg_q.integ_gain <= cfg_data[dwsp_pkg::GAIN_W-1:0];
				end
				dwsp_pkg::REG_DERIV_GAIN: begin
					cfg_q.deriv_gain <= cfg_data[dwsp_pkg::GAIN_W-1:0];
				end
				dwsp_pkg::REG_INTEG_LIMIT: begin
					cfg_q.integ_limit <= cfg_data[dwsp_pkg::ILIM_W-1:0];
				end
				dwsp_pkg::REG_DRIVE_LIMIT: begin
					cfg_q.drive_limit <= cfg_data[dwsp_pkg::DLIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign s_tready = adv;
	assign ctl.adv  = adv;
	assign ctl.take = s_tvalid && adv;
	assign ctl.clr  = s_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	dwsp_lane #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_lane_l (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.cfg   (cfg_q),
		.tgt   ($signed(s_tdata[W-1:0])),
		.meas  ($signed(s_tdata[3*W-1:2*W])),
		.drive (drive_l)
	);

	dwsp_lane #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_lane_r (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.cfg   (cfg_q),
		.tgt   ($signed(s_tdata[2*W-1:W])),
		.meas  ($signed(s_tdata[4*W-1:3*W])),
		.drive (drive_r)
	);

	dwsp_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s3),
		.drive_l (drive_l),
		.drive_r (drive_r),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.adv     (adv)
	);

endmodule

/* rtl/core/dwsp_check.sv */
`timescale 1ns / 1ps

module dwsp_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
		else $error("drive outside saturation range");

	a_ready_empty: assert property (@(posedge clk)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output beat during reset");

endmodule

bind dual_wheel_speed_pid_unit dwsp_check u_dwsp_check (.*);
